// ===== hw/rtl/adl_pkg.sv =====
package adl_pkg;

    // Field widths of the item formats
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int OFFSET_W = 9;
    localparam int FREED_W  = 7;
    localparam int FRAME_W  = 32;

    // Command codes
    localparam logic CMD_LOOKUP    = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_in_item;

    typedef struct packed {
        logic                hit;
        logic                allocated;
        logic                no_free_line;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
        logic [ADDR_W-1:0]   fetch_address;
        logic [FREED_W-1:0]  freed_count;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/adl_ram.sv =====
module adl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/audio_dma_line_cache.sv =====
// Fully associative cache of sample DMA lines.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) carries either a
// lookup (address, length) or a frame-end marker. Output channel (o_out_valid /
// i_out_stall, payload o_out_data) returns exactly one result per input item.
// A lookup returns a hit with slot and offset, an allocation with the fetch
// address of the new line, or a no-free-line flag. A frame end returns the
// number of lines released because their stamp is older than the last frame.
// Each item walks all LINE_COUNT lines through the single read port of the
// start and stamp memories, one line per cycle; after the last line is checked,
// the result is registered in the output register once that register is free.
// The input is stalled while an item is in work; the next item is accepted
// while its predecessor's result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// block holds a finished item until that register frees up.
// Reset (synchronous, active low) clears all valid bits, the frame counter and
// the handshake state at once; the memories need no clearing.
module audio_dma_line_cache #(
    parameter int LINE_COUNT = 64,
    parameter int LINE_BYTES = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  adl_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output adl_pkg::t_out_item  o_out_data
);

    import adl_pkg::*;

    localparam int IDX_W = $clog2(LINE_COUNT);
    localparam int CNT_W = $clog2(LINE_COUNT + 1);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(LINE_COUNT);
    localparam logic [ADDR_W:0]  LINE_SPAN = (ADDR_W + 1)'(LINE_BYTES);

    // Control state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_chk_idx;
    logic [LINE_COUNT-1:0] r_line_valid, n_line_valid;
    logic [FRAME_W-1:0]    r_frame, n_frame;
    logic                  r_out_valid, n_out_valid;

    // Item and walk results
    t_in_item              r_item;
    logic                  r_best_found, n_best_found;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [ADDR_W-1:0]     r_best_start, n_best_start;
    logic                  r_free_found, n_free_found;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic [CNT_W-1:0]      r_freed, n_freed;
    t_out_item             r_out_data, n_out_data;

    // Memory ports
    logic [ADDR_W-1:0]     rd_start;
    logic [FRAME_W-1:0]    rd_stamp;
    logic                  start_wr_en, stamp_wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [ADDR_W-1:0]     start_wr_data;

    // Walk decode
    logic                  accept, issue, out_load;
    logic                  rd_line_valid, covers, stale;
    logic [ADDR_W:0]       req_end, line_end;
    logic [FRAME_W-1:0]    stamp_next;

    adl_ram #(.WIDTH(ADDR_W), .DEPTH(LINE_COUNT)) u_start_ram (
        .i_clk     (i_clk),
        .i_wr_en   (start_wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (start_wr_data),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_start)
    );

    adl_ram #(.WIDTH(FRAME_W), .DEPTH(LINE_COUNT)) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stamp_wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (r_frame),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_stamp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Compare the line read back last cycle against the request
    assign rd_line_valid = r_line_valid[r_chk_idx];
    assign req_end       = {1'b0, r_item.address} + (ADDR_W + 1)'(r_item.length);
    assign line_end      = {1'b0, rd_start} + LINE_SPAN;
    assign covers        = rd_line_valid && (rd_start <= r_item.address)
                           && (req_end <= line_end);
    assign stamp_next    = rd_stamp + FRAME_W'(1);
    assign stale         = rd_line_valid && (stamp_next < r_frame);

    // Next state, walk bookkeeping and result
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_line_valid = r_line_valid;
        n_frame      = r_frame;
        n_best_found = r_best_found;
        n_best_idx   = r_best_idx;
        n_best_start = r_best_start;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_freed      = r_freed;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid && i_out_stall;
        issue        = 1'b0;
        out_load     = 1'b0;
        start_wr_en  = 1'b0;
        stamp_wr_en  = 1'b0;
        wr_idx       = r_best_idx;
        start_wr_data = {r_item.address[ADDR_W-1:1], 1'b0};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state      = ST_WALK;
                    n_idx        = '0;
                    n_best_found = 1'b0;
                    n_free_found = 1'b0;
                    n_freed      = '0;
                end
            end
            ST_WALK: begin
                issue = (r_idx != LAST_CNT);
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_state = ST_FINISH;
                end
                if (r_pend) begin
                    if (r_item.command == CMD_FRAME_END) begin
                        if (stale) begin
                            n_line_valid[r_chk_idx] = 1'b0;
                            n_freed = r_freed + CNT_W'(1);
                        end
                    end else begin
                        if (covers && (!r_best_found || rd_start < r_best_start)) begin
                            n_best_found = 1'b1;
                            n_best_idx   = r_chk_idx;
                            n_best_start = rd_start;
                        end
                        if (!rd_line_valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_chk_idx;
                        end
                    end
                end
            end
            ST_FINISH: begin
                out_load = !r_out_valid || !i_out_stall;
                if (out_load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    if (r_item.command == CMD_FRAME_END) begin
                        n_out_data.freed_count = FREED_W'(r_freed);
                        n_frame = r_frame + FRAME_W'(1);
                    end else if (r_best_found) begin
                        stamp_wr_en = 1'b1;
                        wr_idx      = r_best_idx;
                        n_out_data.hit    = 1'b1;
                        n_out_data.slot   = SLOT_W'(r_best_idx);
                        n_out_data.offset = OFFSET_W'(r_item.address - r_best_start);
                    end else if (r_free_found) begin
                        start_wr_en = 1'b1;
                        stamp_wr_en = 1'b1;
                        wr_idx      = r_free_idx;
                        n_line_valid[r_free_idx] = 1'b1;
                        n_out_data.allocated     = 1'b1;
                        n_out_data.slot          = SLOT_W'(r_free_idx);
                        n_out_data.offset        = OFFSET_W'(r_item.address[0]);
                        n_out_data.fetch_address = start_wr_data;
                    end else begin
                        n_out_data.no_free_line = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_line_valid <= '0;
            r_frame      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_pend       <= issue;
            r_line_valid <= n_line_valid;
            r_frame      <= n_frame;
            r_out_valid  <= n_out_valid;
        end
    end

    // Capture the item and walk results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
        r_chk_idx    <= r_idx[IDX_W-1:0];
        r_best_found <= n_best_found;
        r_best_idx   <= n_best_idx;
        r_best_start <= n_best_start;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_freed      <= n_freed;
        r_out_data   <= n_out_data;
    end

    // At most one outcome flag per result
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_out_data.hit, r_out_data.allocated,
                                    r_out_data.no_free_line}) <= 1)
        else $error("more than one outcome flag set");

    // A fetched line always starts on an even address
    a_even_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.allocated) |-> !r_out_data.fetch_address[0])
        else $error("fetch address is odd");

    // Lookup results never report freed lines
    a_no_freed_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.hit || r_out_data.allocated))
        |-> (r_out_data.freed_count == '0))
        else $error("freed count on lookup result");

    // A claimed slot is valid after the allocation
    a_claim_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && start_wr_en) |=> r_line_valid[$past(r_free_idx)])
        else $error("allocated slot not marked valid");

    // Memory reads are only pending during the walk
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_WALK))
        else $error("read pending outside walk");

endmodule
